FILE: design/prhl_pkg.sv
`timescale 1ns / 1ps
package prhl_pkg;

    localparam int BUCKETS_DEF   = 64;
    localparam int ENTRIES_DEF   = 256;
    localparam int PAGE_BITS_DEF = 12;
    localparam int ADDR_BITS_DEF = 48;

    localparam int ADDR_W = 48;
    localparam int SPAN_W = 17;
    localparam int ID_W   = 16;
    localparam int USED_W = 9;

    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_REMOVE = 2'd1;
    localparam logic [1:0] ACT_FIND   = 2'd2;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_IGNORED = 2'd2;

    typedef struct packed {
        logic [1:0]        action;
        logic [ADDR_W-1:0] address;
        logic [SPAN_W-1:0] span_bytes;
        logic [ID_W-1:0]   region_id;
        logic [ID_W-1:0]   owner_id;
    } t_in;

    typedef struct packed {
        logic [1:0]        status;
        logic              found;
        logic [ID_W-1:0]   found_owner;
        logic [USED_W-1:0] entries_used;
    } t_out;

    // one pool entry as held in the data memory
    typedef struct packed {
        logic [ADDR_W-1:0] base;
        logic [ADDR_W:0]   lim;
        logic [ID_W-1:0]   owner;
        logic [ID_W-1:0]   region;
    } t_entry;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_INS_CHK,
        S_INS_WR,
        S_RM_HEAD,
        S_RM_HWAIT,
        S_RM_CHK,
        S_RM_EVAL,
        S_RM_FREE,
        S_FD_HEAD,
        S_FD_HWAIT,
        S_FD_CHK,
        S_FD_EVAL,
        S_DONE
    } t_state;

    // xor fold by 32, 16 and 8; caller masks to the bucket range
    function automatic logic [63:0] bucket_hash(input logic [63:0] page);
        logic [63:0] p;
        p = page;
        p = p ^ (p >> 32);
        p = p ^ (p >> 16);
        p = p ^ (p >> 8);
        return p;
    endfunction

endpackage

FILE: design/page_range_hash_lookup_table_core.sv
`timescale 1ns / 1ps
// Channel   Dir  Handshake          Beat
// -------   ---  -----------------  -------------------------------------
// input     in   i_valid / o_stall  i_in  : action, address, span, ids
// result    out  o_valid / i_stall  o_out : status, found, owner, used
//
// One item at a time; each beat in gives exactly one result beat.
// Find walks the chain of the address's page until an entry covers the address.
// Insert places one entry per page and stops when the pool runs dry. Remove walks
// each page's chain and frees the first entry of the region. Ignored items go
// straight to the result. Each chain step waits on the registered memory reads.
// After reset the bucket heads are swept to null, one per cycle, with o_stall
// high. A finished result waits in the output register while the next beat is
// taken; a new result is held back until the old one is gone.
module page_range_hash_lookup_table_core #(
    parameter int BUCKETS   = prhl_pkg::BUCKETS_DEF,
    parameter int ENTRIES   = prhl_pkg::ENTRIES_DEF,
    parameter int PAGE_BITS = prhl_pkg::PAGE_BITS_DEF,
    parameter int ADDR_BITS = prhl_pkg::ADDR_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  prhl_pkg::t_in  i_in,
    output logic           o_valid,
    input  logic           i_stall,
    output prhl_pkg::t_out o_out
);

    import prhl_pkg::*;

    localparam int BK_W = $clog2(BUCKETS);
    localparam int EA_W = $clog2(ENTRIES);
    localparam int IX_W = $clog2(ENTRIES + 1);
    localparam int PG_W = ADDR_W + 1 - PAGE_BITS;
    localparam int AB   = (ADDR_BITS >= ADDR_W) ? ADDR_W : ADDR_BITS;

    localparam logic [ADDR_W-1:0] AMASK  = {ADDR_W{1'b1}} >> (ADDR_W - AB);
    localparam logic [PG_W-1:0]   PLIMIT = PG_W'({1'b0, AMASK} >> PAGE_BITS);
    localparam logic [IX_W-1:0]   NIL    = IX_W'(ENTRIES);
    localparam logic [BK_W-1:0]   BK_LAST = BK_W'(BUCKETS - 1);

    t_state r_state, n_state;

    // control
    logic [BK_W-1:0] r_clr;
    logic [IX_W-1:0] r_free_head;
    logic [IX_W-1:0] r_fill;     // entries at or above this were never allocated
    logic [IX_W-1:0] r_used;
    logic            r_out_valid;

    // item payload and walk state
    logic [1:0]        r_act;
    logic [ADDR_W-1:0] r_addr;
    logic [SPAN_W-1:0] r_span;
    logic [ADDR_W:0]   r_end;
    logic [ID_W-1:0]   r_region;
    logic [ID_W-1:0]   r_owner;
    logic [PG_W-1:0]   r_page;
    logic [PG_W-1:0]   r_last;
    logic [IX_W-1:0]   r_cur;
    logic [IX_W-1:0]   r_prev;
    logic [IX_W-1:0]   r_steps;
    logic [1:0]        r_status;
    logic              r_found;
    logic [ID_W-1:0]   r_fowner;
    t_out              r_out;

    // memory ports
    logic            bk_we;
    logic [BK_W-1:0] bk_waddr, bk_raddr;
    logic [IX_W-1:0] bk_wdata, bk_rdata;
    logic            dt_we;
    logic [EA_W-1:0] dt_waddr, dt_raddr;
    t_entry          dt_wdata, dt_rdata;
    logic            ln_we;
    logic [EA_W-1:0] ln_waddr, ln_raddr;
    logic [IX_W-1:0] ln_wdata, ln_rdata;

    logic [ADDR_W-1:0] w_addr_m;
    logic [BK_W-1:0]   w_bucket;
    logic [PG_W-1:0]   w_last_raw, w_last;
    logic              w_walk_end, w_page_end, w_match, w_cover, w_out_free;
    logic [IX_W-1:0]   w_next_free;

    assign w_addr_m   = i_in.address & AMASK;
    assign w_bucket   = BK_W'(bucket_hash(64'(r_page)) & 64'(BUCKETS - 1));
    assign w_last_raw = PG_W'((r_end - (ADDR_W + 1)'(1)) >> PAGE_BITS);
    assign w_last     = (w_last_raw > PLIMIT) ? PLIMIT : w_last_raw;
    assign w_walk_end = (r_cur == NIL) || (r_steps == IX_W'(ENTRIES));
    assign w_page_end = (r_page == r_last);
    assign w_match    = (dt_rdata.region == r_region);
    assign w_cover    = ({1'b0, r_addr} >= {1'b0, dt_rdata.base})
                     && ({1'b0, r_addr} < dt_rdata.lim);
    assign w_out_free = !r_out_valid || !i_stall;
    // untouched part of the pool links to the next index
    assign w_next_free = (r_free_head == r_fill) ? (r_free_head + IX_W'(1)) : ln_rdata;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR:    if (r_clr == BK_LAST) n_state = S_IDLE;
            S_IDLE:     if (i_valid) n_state = S_DECODE;
            S_DECODE: begin
                case (r_act)
                    ACT_INSERT, ACT_REMOVE: begin
                        if (r_region == '0 || r_span == '0 || r_page > w_last) begin
                            n_state = S_DONE;
                        end else if (r_act == ACT_INSERT) begin
                            n_state = S_INS_CHK;
                        end else begin
                            n_state = S_RM_HEAD;
                        end
                    end
                    ACT_FIND:   n_state = (r_addr == '0) ? S_DONE : S_FD_HEAD;
                    default:    n_state = S_DONE;
                endcase
            end
            S_INS_CHK:  n_state = (r_free_head == NIL) ? S_DONE : S_INS_WR;
            S_INS_WR:   n_state = w_page_end ? S_DONE : S_INS_CHK;
            S_RM_HEAD:  n_state = S_RM_HWAIT;
            S_RM_HWAIT: n_state = S_RM_CHK;
            S_RM_CHK: begin
                if (!w_walk_end) begin
                    n_state = S_RM_EVAL;
                end else begin
                    n_state = w_page_end ? S_DONE : S_RM_HEAD;
                end
            end
            S_RM_EVAL:  n_state = w_match ? S_RM_FREE : S_RM_CHK;
            S_RM_FREE:  n_state = w_page_end ? S_DONE : S_RM_HEAD;
            S_FD_HEAD:  n_state = S_FD_HWAIT;
            S_FD_HWAIT: n_state = S_FD_CHK;
            S_FD_CHK:   n_state = w_walk_end ? S_DONE : S_FD_EVAL;
            S_FD_EVAL:  n_state = w_cover ? S_DONE : S_FD_CHK;
            S_DONE:     if (w_out_free) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // memory controls
    always_comb begin
        bk_we    = 1'b0;
        bk_waddr = w_bucket;
        bk_wdata = r_free_head;
        bk_raddr = w_bucket;
        dt_we    = 1'b0;
        dt_waddr = r_free_head[EA_W-1:0];
        dt_wdata = '{base: r_addr, lim: r_end, owner: r_owner, region: r_region};
        dt_raddr = r_cur[EA_W-1:0];
        ln_we    = 1'b0;
        ln_waddr = r_free_head[EA_W-1:0];
        ln_wdata = bk_rdata;
        ln_raddr = r_cur[EA_W-1:0];
        case (r_state)
            S_CLEAR: begin
                bk_we    = 1'b1;
                bk_waddr = r_clr;
                bk_wdata = NIL;
            end
            S_INS_CHK: begin
                ln_raddr = r_free_head[EA_W-1:0];
            end
            S_INS_WR: begin
                // new entry goes to the head of its chain
                bk_we = 1'b1;
                dt_we = 1'b1;
                ln_we = 1'b1;
            end
            S_RM_EVAL: begin
                if (w_match) begin
                    if (r_prev != NIL) begin
                        ln_we    = 1'b1;
                        ln_waddr = r_prev[EA_W-1:0];
                        ln_wdata = ln_rdata;
                    end else begin
                        bk_we    = 1'b1;
                        bk_wdata = ln_rdata;
                    end
                end
            end
            S_RM_FREE: begin
                ln_we    = 1'b1;
                ln_waddr = r_cur[EA_W-1:0];
                ln_wdata = r_free_head;
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_free_head <= '0;
            r_fill      <= '0;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            // result register loads only when empty or draining this cycle
            if (r_state == S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: r_clr <= r_clr + BK_W'(1);
                S_INS_WR: begin
                    r_free_head <= w_next_free;
                    if (r_free_head == r_fill) begin
                        r_fill <= r_fill + IX_W'(1);
                    end
                    r_used <= r_used + IX_W'(1);
                end
                S_RM_FREE: begin
                    r_free_head <= r_cur;
                    if (r_used != '0) begin
                        r_used <= r_used - IX_W'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // payload and walk registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    r_act    <= i_in.action;
                    r_addr   <= w_addr_m;
                    r_span   <= i_in.span_bytes;
                    r_end    <= {1'b0, w_addr_m} + (ADDR_W + 1)'(i_in.span_bytes);
                    r_region <= i_in.region_id;
                    r_owner  <= i_in.owner_id;
                    r_page   <= PG_W'(w_addr_m >> PAGE_BITS);
                    r_status <= ST_DONE;
                    r_found  <= 1'b0;
                    r_fowner <= '0;
                end
            end
            S_DECODE: begin
                r_last <= w_last;
                case (r_act)
                    ACT_INSERT, ACT_REMOVE: if (r_region == '0) r_status <= ST_IGNORED;
                    ACT_FIND:               if (r_addr == '0) r_status <= ST_IGNORED;
                    default:                r_status <= ST_IGNORED;
                endcase
            end
            S_INS_CHK: if (r_free_head == NIL) r_status <= ST_FULL;
            S_INS_WR:  r_page <= r_page + PG_W'(1);
            S_RM_HWAIT, S_FD_HWAIT: begin
                r_cur   <= bk_rdata;
                r_prev  <= NIL;
                r_steps <= '0;
            end
            S_RM_CHK:  if (w_walk_end) r_page <= r_page + PG_W'(1);
            S_RM_EVAL: begin
                if (!w_match) begin
                    r_prev  <= r_cur;
                    r_cur   <= ln_rdata;
                    r_steps <= r_steps + IX_W'(1);
                end
            end
            S_RM_FREE: r_page <= r_page + PG_W'(1);
            S_FD_EVAL: begin
                if (w_cover) begin
                    r_found  <= 1'b1;
                    r_fowner <= dt_rdata.owner;
                end else begin
                    r_cur   <= ln_rdata;
                    r_steps <= r_steps + IX_W'(1);
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    r_out.status       <= r_status;
                    r_out.found        <= r_found;
                    r_out.found_owner  <= r_fowner;
                    r_out.entries_used <= USED_W'(r_used);
                end
            end
            default: begin
            end
        endcase
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;
    assign o_out   = r_out;

    prhl_ram #(.WIDTH(IX_W), .DEPTH(BUCKETS)) u_bucket_ram (
        .i_clk   (i_clk),
        .i_we    (bk_we),
        .i_waddr (bk_waddr),
        .i_wdata (bk_wdata),
        .i_raddr (bk_raddr),
        .o_rdata (bk_rdata)
    );

    prhl_ram #(.WIDTH($bits(t_entry)), .DEPTH(ENTRIES)) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (dt_we),
        .i_waddr (dt_waddr),
        .i_wdata (dt_wdata),
        .i_raddr (dt_raddr),
        .o_rdata (dt_rdata)
    );

    prhl_ram #(.WIDTH(IX_W), .DEPTH(ENTRIES)) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (ln_we),
        .i_waddr (ln_waddr),
        .i_wdata (ln_wdata),
        .i_raddr (ln_raddr),
        .o_rdata (ln_rdata)
    );

`ifndef NO_ASSERTIONS
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= IX_W'(ENTRIES))
        else $error("entry count above pool size");

    a_free_head_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free_head <= r_fill)
        else $error("free head beyond allocated region");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state) == S_DONE)
        else $error("result beat raised outside completion");

    a_alloc_nonnull: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dt_we |-> (r_free_head != NIL) && (r_used != IX_W'(ENTRIES)))
        else $error("entry written with empty pool");
`endif

endmodule

FILE: design/prhl_ram.sv
`timescale 1ns / 1ps
module prhl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
